>>> src/hid_input_report_scheduler_assert.svh
// Assertion macros used by the scheduler datapath module.
`ifndef HID_INPUT_REPORT_SCHEDULER_ASSERT_SVH
`define HID_INPUT_REPORT_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

`define HIRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hirs assertion failed");

`define HIRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hirs assertion failed");

`else

`define HIRS_ASSERT_IMPL(label, clk, rst, ante, cons)

`define HIRS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/hirs_pkg.sv
`timescale 1ns / 1ps

package hirs_pkg;

  localparam logic [2:0] KIND_TICK = 3'd0;
  localparam logic [2:0] KIND_CHG  = 3'd1;
  localparam logic [2:0] KIND_DONE = 3'd2;
  localparam logic [2:0] KIND_SET  = 3'd3;
  localparam logic [2:0] KIND_DEF  = 3'd4;

  typedef enum logic [2:0] {
    MODE_TICK,
    MODE_SET,
    MODE_CHG,
    MODE_DEF,
    MODE_SCAN
  } mode_t;

  typedef struct packed {
    logic  load;
    logic  start;
    mode_t mode;
    logic  issue;
    logic  note_cap;
    logic  emit_note;
    logic  emit_send;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic at_end;
    logic p_valid;
    logic found;
    logic out_free;
  } stat_t;

endpackage

>>> src/hirs_ctrl.sv
`timescale 1ns / 1ps

module hirs_ctrl #(
  parameter int MAX_REPORTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          kind,
  input  logic [3:0]          report_index,
  input  hirs_pkg::stat_t     st,
  output hirs_pkg::cmd_t      cmd
);
  import hirs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_SCAN_INIT,
    S_NOTE,
    S_SEND
  } state_t;

  state_t state;
  logic   do_scan;
  logic   in_scan;
  logic   with_note;
  logic   accept;
  logic   idx_ok;
  logic   sweep_done;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign idx_ok     = int'(report_index) < MAX_REPORTS;
  assign sweep_done = st.at_end && !st.p_valid;

  always_comb begin
    cmd = '0;
    cmd.mode = MODE_TICK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (kind)
            KIND_TICK: begin
              cmd.start = 1'b1;
              cmd.mode  = MODE_TICK;
            end
            KIND_CHG: begin
              cmd.start = idx_ok;
              cmd.mode  = MODE_CHG;
            end
            KIND_DONE: begin
              cmd.note_cap = st.busy;
            end
            KIND_SET: begin
              cmd.start = 1'b1;
              cmd.mode  = MODE_SET;
            end
            KIND_DEF: begin
              cmd.start = idx_ok;
              cmd.mode  = MODE_DEF;
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
      end
      S_SCAN_INIT: begin
        cmd.start = !st.busy;
        cmd.mode  = MODE_SCAN;
      end
      S_NOTE: begin
        cmd.emit_note = st.out_free;
      end
      S_SEND: begin
        cmd.emit_send = st.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      do_scan   <= 1'b0;
      in_scan   <= 1'b0;
      with_note <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            do_scan   <= 1'b0;
            in_scan   <= 1'b0;
            with_note <= 1'b0;
            unique case (kind)
              KIND_TICK: begin
                do_scan <= 1'b1;
                state   <= S_SWEEP;
              end
              KIND_CHG: begin
                if (idx_ok) begin
                  do_scan <= 1'b1;
                  state   <= S_SWEEP;
                end
              end
              KIND_DONE: begin
                if (st.busy) begin
                  with_note <= 1'b1;
                  state     <= S_SCAN_INIT;
                end
              end
              KIND_SET: begin
                state <= S_SWEEP;
              end
              KIND_DEF: begin
                if (idx_ok) begin
                  state <= S_SWEEP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (sweep_done) begin
            if (in_scan) begin
              if (with_note) begin
                state <= S_NOTE;
              end else if (st.found) begin
                state <= S_SEND;
              end else begin
                state <= S_IDLE;
              end
            end else if (do_scan) begin
              state <= S_SCAN_INIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SCAN_INIT: begin
          if (st.busy) begin
            state <= S_IDLE;
          end else begin
            in_scan <= 1'b1;
            state   <= S_SWEEP;
          end
        end
        S_NOTE: begin
          if (st.out_free) begin
            state <= st.found ? S_SEND : S_IDLE;
          end
        end
        S_SEND: begin
          if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/hirs_dp.sv
`timescale 1ns / 1ps
`include "hid_input_report_scheduler_assert.svh"

module hirs_dp #(
  parameter int MAX_REPORTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [4:0]      cfg_data,
  input  logic [3:0]      report_index,
  input  logic [7:0]      req_id,
  input  logic [7:0]      idle_value,
  input  logic            is_input,
  input  hirs_pkg::cmd_t  cmd,
  output hirs_pkg::stat_t st,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            result_kind,
  output logic [3:0]      out_index,
  output logic [7:0]      out_id,
  output logic            last
);
  import hirs_pkg::*;

  localparam int IDXW = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;
  localparam int CNTW = $clog2(MAX_REPORTS + 1);

  typedef struct packed {
    logic [7:0] id;
    logic       inp;
    logic [7:0] rate;
    logic [7:0] count;
    logic       pend;
  } entry_t;

  entry_t                 entry_mem [MAX_REPORTS];
  logic [MAX_REPORTS-1:0] entry_vld;
  entry_t                 rd_data;
  logic                   rd_vld;

  logic [4:0]      num_reports;
  logic [CNTW-1:0] addr;
  logic [CNTW-1:0] sw_end;
  logic [CNTW-1:0] p_addr;
  logic            p_valid;
  mode_t           mode;
  logic [7:0]      cap_id;
  logic [7:0]      cap_val;
  logic            cap_inp;
  logic            busy;
  logic            found;
  logic [CNTW-1:0] scan_pos;
  logic [7:0]      inflight_id;
  logic [7:0]      note_id;
  logic [3:0]      send_index;

  logic [CNTW-1:0] n;
  logic [CNTW-1:0] idx_cnt;
  logic            issue_ok;
  logic            p_last;
  logic            out_free;
  logic            hit;
  entry_t          cur;
  entry_t          upd;

  assign n = (int'(num_reports) > MAX_REPORTS) ? CNTW'(MAX_REPORTS) : CNTW'(num_reports);
  assign idx_cnt  = CNTW'(report_index);
  assign issue_ok = cmd.issue && (addr < sw_end);
  assign p_last   = (p_addr + CNTW'(1)) == sw_end;
  assign out_free = !out_valid || out_ready;
  assign cur      = rd_vld ? rd_data : '0;

  always_comb begin
    upd = cur;
    hit = 1'b0;
    unique case (mode)
      MODE_TICK: begin
        if (cur.inp && (cur.rate != 8'd0) && (cur.count != 8'hFF)) begin
          upd.count = cur.count + 8'd1;
        end
      end
      MODE_SET: begin
        if (cur.inp && ((cap_id == 8'd0) || (cur.id == cap_id))) begin
          upd.rate = cap_val;
        end
      end
      MODE_CHG: begin
        upd.pend = 1'b1;
      end
      MODE_DEF: begin
        upd.id  = cap_id;
        upd.inp = cap_inp;
      end
      MODE_SCAN: begin
        if (p_valid && cur.inp &&
            (cur.pend || ((cur.rate != 8'd0) && (cur.count >= cur.rate)))) begin
          hit        = 1'b1;
          upd.pend   = 1'b0;
          upd.count  = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  assign st.busy     = busy;
  assign st.at_end   = !(addr < sw_end);
  assign st.p_valid  = p_valid;
  assign st.found    = found;
  assign st.out_free = out_free;

  always_ff @(posedge clk) begin
    if (issue_ok) begin
      rd_data <= entry_mem[addr[IDXW-1:0]];
    end
    if (p_valid) begin
      entry_mem[p_addr[IDXW-1:0]] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_reports <= '0;
      entry_vld   <= '0;
      rd_vld      <= 1'b0;
      addr        <= '0;
      sw_end      <= '0;
      p_valid     <= 1'b0;
      mode        <= MODE_TICK;
      busy        <= 1'b0;
      found       <= 1'b0;
      scan_pos    <= '0;
      inflight_id <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        num_reports <= cfg_data;
      end
      p_valid <= issue_ok && !hit;
      if (issue_ok) begin
        if (!hit) begin
          addr <= addr + CNTW'(1);
        end
        rd_vld <= entry_vld[addr[IDXW-1:0]];
      end
      if (cmd.start) begin
        mode <= cmd.mode;
        unique case (cmd.mode)
          MODE_TICK, MODE_SET: begin
            addr   <= '0;
            sw_end <= n;
          end
          MODE_CHG, MODE_DEF: begin
            addr   <= idx_cnt;
            sw_end <= idx_cnt + CNTW'(1);
          end
          MODE_SCAN: begin
            found  <= 1'b0;
            sw_end <= n;
            if (scan_pos >= n) begin
              addr     <= '0;
              scan_pos <= '0;
            end else begin
              addr <= scan_pos;
            end
          end
          default: begin
          end
        endcase
      end
      if (p_valid) begin
        entry_vld[p_addr[IDXW-1:0]] <= 1'b1;
        if (hit) begin
          busy        <= 1'b1;
          found       <= 1'b1;
          scan_pos    <= p_addr + CNTW'(1);
          inflight_id <= cur.id;
          addr        <= sw_end;
        end else if ((mode == MODE_SCAN) && p_last) begin
          scan_pos <= sw_end;
        end
      end
      if (cmd.note_cap) begin
        busy <= 1'b0;
      end
      if (cmd.emit_note || cmd.emit_send) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cap_id  <= req_id;
      cap_val <= idle_value;
      cap_inp <= is_input;
    end
    if (issue_ok) begin
      p_addr <= addr;
    end
    if (cmd.note_cap) begin
      note_id <= inflight_id;
    end
    if (hit) begin
      send_index <= 4'(p_addr);
    end
    if (cmd.emit_note) begin
      result_kind <= 1'b1;
      out_index   <= 4'd0;
      out_id      <= note_id;
      last        <= !found;
    end else if (cmd.emit_send) begin
      result_kind <= 1'b0;
      out_index   <= send_index;
      out_id      <= inflight_id;
      last        <= 1'b1;
    end
  end

  `HIRS_ASSERT_IMPL(a_emit_free, clk, rst, cmd.emit_note || cmd.emit_send, out_free)
  `HIRS_ASSERT_NEXT(a_hit_busy, clk, rst, hit, busy && found && !p_valid)
  `HIRS_ASSERT_IMPL(a_pipe_range, clk, rst, p_valid, p_addr < sw_end)
  `HIRS_ASSERT_IMPL(a_send_found, clk, rst, cmd.emit_send, found)

endmodule

>>> src/hid_input_report_scheduler.sv
`timescale 1ns / 1ps
// HID input report scheduler.
// Input items (kind, report_index, req_id, idle_value, is_input) arrive on the
// in_valid/in_ready channel. Result items (result_kind, out_index, out_id, last)
// leave on the out_valid/out_ready channel; last marks the final result of an item.
// The num_reports register is written on cfg_valid/cfg_ready, which is always ready.
// One item is worked on at a time. Report table entries live in a single memory
// swept one entry per cycle through a registered read. With n entries in use, a
// tick sweeps the counts, then, if no report is in flight, scans and sends; a set
// idle sweeps n entries; a define entry or report changed writes one entry, the
// latter then scans and sends; a send done scans, emits a note, then any send.
// A final result waits in the output register while the next item is accepted;
// when out_ready is low with a result still pending, the block holds in its emit
// step until the receiver takes the earlier result.
// Reset is synchronous: it clears the table, busy flag, scan position, in-flight
// id and num_reports. There is no clearing pass; entries read as zero until
// first written.

module hid_input_report_scheduler #(
  parameter int MAX_REPORTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] kind,
  input  logic [3:0] report_index,
  input  logic [7:0] req_id,
  input  logic [7:0] idle_value,
  input  logic       is_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       result_kind,
  output logic [3:0] out_index,
  output logic [7:0] out_id,
  output logic       last
);
  import hirs_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  hirs_ctrl #(
    .MAX_REPORTS(MAX_REPORTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .report_index(report_index),
    .st          (st),
    .cmd         (cmd)
  );

  hirs_dp #(
    .MAX_REPORTS(MAX_REPORTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .report_index(report_index),
    .req_id      (req_id),
    .idle_value  (idle_value),
    .is_input    (is_input),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .out_index   (out_index),
    .out_id      (out_id),
    .last        (last)
  );

endmodule
